### design/ctdt_pkg.sv
// Shared types and constants for the Canny double-threshold unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ctdt_pkg;

    localparam int RATIO_BITS = 17;
    localparam int RATIO_FRAC = 16;
    localparam int LEVEL_BITS = 8;
    localparam int ALPHA_BITS = 8;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [RATIO_BITS-1:0] RATIO_ONE        = 17'h10000;
    localparam logic [RATIO_BITS-1:0] LOW_RATIO_RESET  = 17'd9830;
    localparam logic [RATIO_BITS-1:0] HIGH_RATIO_RESET = 17'd19661;

    localparam logic [LEVEL_BITS-1:0] LEVEL_STRONG = 8'd255;
    localparam logic [LEVEL_BITS-1:0] LEVEL_WEAK   = 8'd25;
    localparam logic [LEVEL_BITS-1:0] LEVEL_NONE   = 8'd0;

    // register indexes on the configuration port
    localparam logic CFG_LOW_RATIO  = 1'b0;
    localparam logic CFG_HIGH_RATIO = 1'b1;

    // pass selector carried in tuser bit 0
    localparam logic CMD_MEASURE  = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;

    typedef enum logic
    {
        ENT_CLASSIFY = 1'b0,
        ENT_LATCH    = 1'b1
    } entry_kind_t;

    typedef enum logic [2:0]
    {
        BK_RUN,
        BK_MUL_HI,
        BK_SET_HI,
        BK_MUL_LO,
        BK_SET_LO
    } bk_state_t;

    typedef struct packed
    {
        logic empty;
        logic full;
    } q_status_t;

    // ratios above 1.0 are clamped so a threshold never exceeds its source
    function automatic logic [RATIO_BITS-1:0] sat_ratio(input logic [RATIO_BITS-1:0] r);
        return (r > RATIO_ONE) ? RATIO_ONE : r;
    endfunction

endpackage

### design/ctdt_fifo.sv
// Short register queue between the front and back parts.
// Depends on ctdt_pkg for the status struct.
`timescale 1ns / 1ps

module ctdt_fifo #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [WIDTH-1:0]      wr_data,
    input  logic                  pop,
    output logic [WIDTH-1:0]      rd_data,
    output ctdt_pkg::q_status_t   status
);
    import ctdt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == FULL_CNT);
    assign rd_data      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!status.full || pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("queue read while empty");

endmodule

### design/ctdt_front.sv
// Front part: accepts pixels, tracks the running maximum, queues work for the back.
// Depends on ctdt_pkg for pass codes and entry kinds.
`timescale 1ns / 1ps

module ctdt_front #(
    parameter int PIXEL_BITS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               cmd,
    input  logic [PIXEL_BITS-1:0]              pixel_red,
    input  logic [ctdt_pkg::ALPHA_BITS-1:0]    pixel_alpha,
    input  logic                               frame_start,
    input  logic                               frame_end,
    input  ctdt_pkg::q_status_t                q_status,
    output logic                               push,
    output logic [PIXEL_BITS+ctdt_pkg::ALPHA_BITS:0] entry
);
    import ctdt_pkg::*;

    logic [PIXEL_BITS-1:0] max_reg, max_next;
    logic [PIXEL_BITS-1:0] max_base;
    logic                  accept;
    entry_kind_t           kind;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        max_base = frame_start ? '0 : max_reg;
        max_next = (pixel_red > max_base) ? pixel_red : max_base;
        kind     = (cmd == CMD_CLASSIFY) ? ENT_CLASSIFY : ENT_LATCH;
        push     = accept && ((cmd == CMD_CLASSIFY) || frame_end);
        // a latch request carries the final maximum, including this pixel
        entry    = {pixel_alpha, (cmd == CMD_CLASSIFY) ? pixel_red : max_next, kind};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= '0;
        end
        else if (accept && (cmd == CMD_MEASURE))
        begin
            max_reg <= max_next;
        end
    end

endmodule

### design/ctdt_back.sv
// Back part: holds the ratios and thresholds, classifies pixels, computes thresholds.
// Depends on ctdt_pkg for states, levels, register indexes and ratio clamping.
`timescale 1ns / 1ps

module ctdt_back #(
    parameter int PIXEL_BITS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [ctdt_pkg::RATIO_BITS-1:0]    cfg_data,
    input  ctdt_pkg::q_status_t                q_status,
    input  logic [PIXEL_BITS+ctdt_pkg::ALPHA_BITS:0] entry,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [ctdt_pkg::LEVEL_BITS-1:0]    level_value,
    output logic [ctdt_pkg::ALPHA_BITS-1:0]    alpha_out
);
    import ctdt_pkg::*;

    localparam int PROD_W = PIXEL_BITS + RATIO_BITS;

    bk_state_t state_reg, state_next;

    logic [RATIO_BITS-1:0] low_ratio_reg, high_ratio_reg;
    logic [PIXEL_BITS-1:0] high_thr_reg, high_thr_next;
    logic [PIXEL_BITS-1:0] low_thr_reg, low_thr_next;
    logic [PIXEL_BITS-1:0] mul_a_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [LEVEL_BITS-1:0] level_reg, level_next;
    logic [ALPHA_BITS-1:0] alpha_reg;

    entry_kind_t           ent_kind;
    logic [PIXEL_BITS-1:0] ent_value;
    logic [ALPHA_BITS-1:0] ent_alpha;
    logic                  slot_free;
    logic [PIXEL_BITS-1:0] mul_a;
    logic [RATIO_BITS-1:0] mul_r;
    logic [PROD_W-1:0]     prod_next;

    assign ent_kind  = entry_kind_t'(entry[0]);
    assign ent_value = entry[1 +: PIXEL_BITS];
    assign ent_alpha = entry[PIXEL_BITS+1 +: ALPHA_BITS];

    assign out_valid   = out_valid_reg;
    assign level_value = level_reg;
    assign alpha_out   = alpha_reg;

    // one shared multiplier, high threshold first, then low from the new high
    assign mul_a     = (state_reg == BK_MUL_HI) ? mul_a_reg : high_thr_reg;
    assign mul_r     = (state_reg == BK_MUL_HI) ? sat_ratio(high_ratio_reg)
                                                : sat_ratio(low_ratio_reg);
    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_r);

    always_comb
    begin
        state_next     = state_reg;
        high_thr_next  = high_thr_reg;
        low_thr_next   = low_thr_reg;
        out_valid_next = out_valid_reg;
        level_next     = level_reg;
        slot_free      = !out_valid_reg || out_ready;
        pop            = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            BK_RUN:
            begin
                if (!q_status.empty)
                begin
                    if (ent_kind == ENT_LATCH)
                    begin
                        pop        = 1'b1;
                        state_next = BK_MUL_HI;
                    end
                    else if (slot_free)
                    begin
                        pop            = 1'b1;
                        out_valid_next = 1'b1;
                        if (ent_value >= high_thr_reg)
                        begin
                            level_next = LEVEL_STRONG;
                        end
                        else if (ent_value >= low_thr_reg)
                        begin
                            level_next = LEVEL_WEAK;
                        end
                        else
                        begin
                            level_next = LEVEL_NONE;
                        end
                    end
                end
            end
            BK_MUL_HI:
            begin
                state_next = BK_SET_HI;
            end
            BK_SET_HI:
            begin
                high_thr_next = prod_reg[RATIO_FRAC +: PIXEL_BITS];
                state_next    = BK_MUL_LO;
            end
            BK_MUL_LO:
            begin
                state_next = BK_SET_LO;
            end
            BK_SET_LO:
            begin
                low_thr_next = prod_reg[RATIO_FRAC +: PIXEL_BITS];
                state_next   = BK_RUN;
            end
            default:
            begin
                state_next = BK_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_RUN;
            high_thr_reg   <= '0;
            low_thr_reg    <= '0;
            out_valid_reg  <= 1'b0;
            low_ratio_reg  <= LOW_RATIO_RESET;
            high_ratio_reg <= HIGH_RATIO_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            high_thr_reg  <= high_thr_next;
            low_thr_reg   <= low_thr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && (cfg_index == CFG_LOW_RATIO))
            begin
                low_ratio_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == CFG_HIGH_RATIO))
            begin
                high_ratio_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg <= level_next;
        if (pop && (ent_kind == ENT_CLASSIFY))
        begin
            alpha_reg <= ent_alpha;
        end
        if (pop && (ent_kind == ENT_LATCH))
        begin
            mul_a_reg <= ent_value;
        end
        if ((state_reg == BK_MUL_HI) || (state_reg == BK_MUL_LO))
        begin
            prod_reg <= prod_next;
        end
    end

    a_low_below_high: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_SET_LO) |=> (low_thr_reg <= high_thr_reg))
        else $error("low threshold above high threshold");

    a_high_below_max: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_SET_HI) |=> (high_thr_reg <= mul_a_reg))
        else $error("high threshold above frame maximum");

    a_no_pop_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == BK_RUN))
        else $error("queue read during threshold update");

    a_latch_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_MUL_HI) |=> (state_reg == BK_SET_HI) ##1 (state_reg == BK_MUL_LO))
        else $error("threshold update out of order");

endmodule

### design/canny_double_threshold_unit.sv
// Top level of the Canny double-threshold unit: front, queue and back.
// Depends on ctdt_pkg, ctdt_front, ctdt_fifo and ctdt_back.
//
// channel   dir  handshake                       contents
// s_axis    in   s_axis_tvalid / s_axis_tready   tdata pixels, tuser pass+start, tlast end
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata level and alpha
// cfg       in   cfg_we                          cfg_index, cfg_data (Q1.16 ratios)
//
// A pixel is taken every cycle while the four-entry queue has room. Classify
// pixels leave the back part at one per cycle while the output is accepted and no
// threshold update runs. A frame-end pixel holds the back part in its multiply and
// set states while the single multiplier produces the high, then the low threshold.
// Reset clears the maximum, the thresholds and the queue; ratios return to
// 0.15 and 0.3. A stalled output register holds its request and backs up the queue.
`timescale 1ns / 1ps

module canny_double_threshold_unit #(
    parameter int PIXEL_BITS = 8
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [PIXEL_BITS-1:0] pixel_red, [PIXEL_BITS+7:PIXEL_BITS] pixel_alpha, zero padded
    input  logic [((PIXEL_BITS+ctdt_pkg::ALPHA_BITS+7)/8)*8-1:0] s_axis_tdata,
    // [0] cmd, [1] frame_start
    input  logic [1:0]                               s_axis_tuser,
    input  logic                                     s_axis_tlast,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // [7:0] level_value, [15:8] alpha_out
    output logic [15:0]                              m_axis_tdata,
    input  logic                                     cfg_we,
    input  logic                                     cfg_index,
    input  logic [ctdt_pkg::RATIO_BITS-1:0]          cfg_data
);
    import ctdt_pkg::*;

    localparam int ENT_W = PIXEL_BITS + ALPHA_BITS + 1;

    logic             push;
    logic             pop;
    logic [ENT_W-1:0] wr_entry;
    logic [ENT_W-1:0] rd_entry;
    q_status_t        q_status;
    logic [LEVEL_BITS-1:0] level_value;
    logic [ALPHA_BITS-1:0] alpha_out;

    assign m_axis_tdata = {alpha_out, level_value};

    ctdt_front #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .cmd         (s_axis_tuser[0]),
        .pixel_red   (s_axis_tdata[PIXEL_BITS-1:0]),
        .pixel_alpha (s_axis_tdata[PIXEL_BITS +: ALPHA_BITS]),
        .frame_start (s_axis_tuser[1]),
        .frame_end   (s_axis_tlast),
        .q_status    (q_status),
        .push        (push),
        .entry       (wr_entry)
    );

    ctdt_fifo #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_entry),
        .pop     (pop),
        .rd_data (rd_entry),
        .status  (q_status)
    );

    ctdt_back #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_status    (q_status),
        .entry       (rd_entry),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .level_value (level_value),
        .alpha_out   (alpha_out)
    );

endmodule
